// ===== hw/rtl/bgrx_to_yuv420_planar_assert.svh =====
// assertion macros for the bgrx to yuv420 converter
// expects clk and rst_n in the scope of the module that includes it
`ifndef BGRX_TO_YUV420_PLANAR_ASSERT_SVH
`define BGRX_TO_YUV420_PLANAR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BGRX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgrx same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BGRX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgrx next-cycle check failed");

`endif

// ===== hw/rtl/bgrx_pkg.sv =====
// shared types and constants for the bgrx to yuv420 converter
// no dependencies
package bgrx_pkg;

  localparam int CFG_W     = 13;
  localparam int OFF_W     = 25;
  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  // bt.601 integer coefficients
  localparam logic [SUM_W-1:0] Y_R = 16'd66;
  localparam logic [SUM_W-1:0] Y_G = 16'd129;
  localparam logic [SUM_W-1:0] Y_B = 16'd25;
  localparam logic [SUM_W-1:0] U_R = 16'd38;   // subtracted
  localparam logic [SUM_W-1:0] U_G = 16'd74;   // subtracted
  localparam logic [SUM_W-1:0] U_B = 16'd112;
  localparam logic [SUM_W-1:0] V_R = 16'd112;
  localparam logic [SUM_W-1:0] V_G = 16'd94;   // subtracted
  localparam logic [SUM_W-1:0] V_B = 16'd18;   // subtracted
  localparam logic [SAMPLE_W-1:0] Y_OFFSET = 8'd16;
  // 128 << 8, folded in before the shift so the floor stays exact
  localparam logic [SUM_W-1:0] C_BIAS = 16'd32768;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // one classified pixel on its way to the emitter
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
    logic                chroma;
    logic                frame_end;
    logic [OFF_W-1:0]    luma_off;
    logic [OFF_W-1:0]    u_off;
    logic [OFF_W-1:0]    v_off;
  } pixel_desc_t;

endpackage

// ===== hw/rtl/bgrx_front.sv =====
// front end: size registers, raster position, offsets and color math
// depends on bgrx_pkg
module bgrx_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [bgrx_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_red,
  input  logic                        q_full,
  output logic                        q_push,
  output bgrx_pkg::pixel_desc_t       q_data
);
  import bgrx_pkg::*;

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_HEIGHT);
  localparam int XW = ((EW > EH) ? EW : EH) > CFG_W ? ((EW > EH) ? EW : EH) : CFG_W;
  localparam int AW = EW + EH;

  logic [CFG_W-1:0] width_r, height_r;
  logic [1:0]       restart_cnt_r;
  logic [AW-1:0]    area_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [LW-1:0]    line_r, line_nxt;
  logic [OFF_W-1:0] luma_off_r, luma_off_nxt;
  logic [OFF_W-1:0] u_off_r, u_off_nxt;
  logic [OFF_W-1:0] v_off_r, v_off_nxt;

  logic [XW-1:0]    w_x, h_x;
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  logic [OFF_W-1:0] u_base, v_base;
  logic [EW-1:0]    col_inc;
  logic [EH-1:0]    line_inc;
  logic             chroma, frame_end, load_bases;
  logic [SUM_W-1:0] b16, g16, r16, y_sum, u_sum, v_sum;
  logic [SAMPLE_W-1:0] luma;

  // clamp to the legal range and force even
  always_comb begin
    w_x = XW'(width_r);
    if (w_x < XW'(2)) w_x = XW'(2);
    if (w_x > XW'(MAX_WIDTH)) w_x = XW'(MAX_WIDTH);
    w_x[0] = 1'b0;
    if (w_x < XW'(2)) w_x = XW'(2);
    h_x = XW'(height_r);
    if (h_x < XW'(2)) h_x = XW'(2);
    if (h_x > XW'(MAX_HEIGHT)) h_x = XW'(MAX_HEIGHT);
    h_x[0] = 1'b0;
    if (h_x < XW'(2)) h_x = XW'(2);
    eff_w = EW'(w_x);
    eff_h = EH'(h_x);
  end

  // plane bases from the registered frame area
  assign u_base = OFF_W'(area_r);
  assign v_base = OFF_W'(area_r + (area_r >> 2));

  // size registers and restart sequencing
  always_ff @(posedge clk) begin
    area_r <= AW'(eff_w) * AW'(eff_h);
    if (!rst_n) begin
      width_r       <= CFG_W'(640);
      height_r      <= CFG_W'(480);
      restart_cnt_r <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_r       <= cfg_wdata;
          restart_cnt_r <= 2'd2;
        end
        REG_FRAME_HEIGHT: begin
          height_r      <= cfg_wdata;
          restart_cnt_r <= 2'd2;
        end
        default: begin
          if (restart_cnt_r != 2'd0) restart_cnt_r <= restart_cnt_r - 2'd1;
        end
      endcase
    end else if (restart_cnt_r != 2'd0) begin
      restart_cnt_r <= restart_cnt_r - 2'd1;
    end
  end

  assign in_ready = !q_full && (restart_cnt_r == 2'd0);
  assign q_push   = in_valid && in_ready;

  // pixel classification
  assign col_inc   = EW'(col_r) + EW'(1);
  assign line_inc  = EH'(line_r) + EH'(1);
  assign chroma    = !line_r[0] && !col_r[0];
  assign frame_end = (col_inc >= eff_w) && (line_inc >= eff_h);
  assign load_bases = (restart_cnt_r == 2'd1) || (q_push && frame_end);

  // raster position and offsets
  always_comb begin
    col_nxt      = col_r;
    line_nxt     = line_r;
    luma_off_nxt = luma_off_r;
    u_off_nxt    = u_off_r;
    v_off_nxt    = v_off_r;
    if (load_bases) begin
      col_nxt      = '0;
      line_nxt     = '0;
      luma_off_nxt = '0;
      u_off_nxt    = u_base;
      v_off_nxt    = v_base;
    end else if (q_push) begin
      luma_off_nxt = luma_off_r + OFF_W'(1);
      if (chroma) begin
        u_off_nxt = u_off_r + OFF_W'(1);
        v_off_nxt = v_off_r + OFF_W'(1);
      end
      if (col_inc >= eff_w) begin
        col_nxt  = '0;
        line_nxt = LW'(line_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      line_r     <= '0;
      luma_off_r <= '0;
      u_off_r    <= '0;
      v_off_r    <= '0;
    end else begin
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      luma_off_r <= luma_off_nxt;
      u_off_r    <= u_off_nxt;
      v_off_r    <= v_off_nxt;
    end
  end

  // color conversion, all sums fit 16 bits unsigned
  assign b16   = SUM_W'(in_blue);
  assign g16   = SUM_W'(in_green);
  assign r16   = SUM_W'(in_red);
  assign y_sum = Y_R * r16 + Y_G * g16 + Y_B * b16;
  assign u_sum = C_BIAS + U_B * b16 - U_R * r16 - U_G * g16;
  assign v_sum = C_BIAS + V_R * r16 - V_G * g16 - V_B * b16;
  assign luma  = y_sum[SUM_W-1:8] + Y_OFFSET;

  always_comb begin
    q_data.luma      = luma;
    q_data.cb        = u_sum[SUM_W-1:8];
    q_data.cr        = v_sum[SUM_W-1:8];
    q_data.chroma    = chroma;
    q_data.frame_end = frame_end;
    q_data.luma_off  = luma_off_r;
    q_data.u_off     = u_off_r;
    q_data.v_off     = v_off_r;
  end

endmodule

// ===== hw/rtl/bgrx_queue.sv =====
// short register queue between front end and emitter
// depends on bgrx_pkg
module bgrx_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bgrx_pkg::pixel_desc_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output bgrx_pkg::pixel_desc_t head_data
);
  import bgrx_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  pixel_desc_t   entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full       = (count_r == NW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) count_r <= count_r + NW'(1);
      else if (pop && !push) count_r <= count_r - NW'(1);
    end
  end

endmodule

// ===== hw/rtl/bgrx_back.sv =====
// emitter: walks each queued pixel into one or three result items
// depends on bgrx_pkg
module bgrx_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  bgrx_pkg::pixel_desc_t          head_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_plane,
  output logic [bgrx_pkg::OFF_W-1:0]     out_buffer_offset,
  output logic [bgrx_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                           out_last_of_pixel,
  output logic                           out_frame_done
);
  import bgrx_pkg::*;

  plane_t              idx_r, idx_nxt;
  logic                valid_r;
  plane_t              plane_r;
  logic [OFF_W-1:0]    offset_r, sel_off;
  logic [SAMPLE_W-1:0] sample_r, sel_sample;
  logic                last_r, done_r;
  logic                load, last_res;

  assign load     = head_valid && (!valid_r || out_ready);
  assign last_res = !head_data.chroma || (idx_r == PLANE_V);
  assign pop      = load && last_res;

  // pick the current plane's sample and offset
  always_comb begin
    idx_nxt = idx_r;
    unique case (idx_r)
      PLANE_Y: begin
        sel_off    = head_data.luma_off;
        sel_sample = head_data.luma;
      end
      PLANE_U: begin
        sel_off    = head_data.u_off;
        sel_sample = head_data.cb;
      end
      PLANE_V: begin
        sel_off    = head_data.v_off;
        sel_sample = head_data.cr;
      end
      default: begin
        sel_off    = head_data.luma_off;
        sel_sample = head_data.luma;
      end
    endcase
    if (load) begin
      if (last_res) idx_nxt = PLANE_Y;
      else if (idx_r == PLANE_Y) idx_nxt = PLANE_U;
      else idx_nxt = PLANE_V;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= PLANE_Y;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      plane_r  <= idx_r;
      offset_r <= sel_off;
      sample_r <= sel_sample;
      last_r   <= last_res;
      done_r   <= last_res && head_data.frame_end;
    end
  end

  assign out_valid         = valid_r;
  assign out_plane         = plane_r;
  assign out_buffer_offset = offset_r;
  assign out_sample        = sample_r;
  assign out_last_of_pixel = last_r;
  assign out_frame_done    = done_r;

endmodule

// ===== hw/rtl/bgrx_to_yuv420_planar.sv =====
// top level of the bgrx to planar yuv 4:2:0 converter
// depends on bgrx_pkg, bgrx_front, bgrx_queue, bgrx_back and the assert header
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_ready  in_blue, in_green, in_red
//   out_        out  out_valid/out_ready out_plane, out_buffer_offset, out_sample,
//                                       out_last_of_pixel, out_frame_done
//   cfg_        in   cfg_we             cfg_index, cfg_wdata
//
// each accepted pixel goes through the queue register and then the output register
// before its first result; the emitter gives one result per cycle while out_ready
// is high: 1 per pixel on odd lines or odd columns, 3 per even-line even-column
// pixel, so 2 results per pixel on average on even lines and 1 on odd lines
// reset and each size write hold in_ready low while the plane bases are
// recomputed; a 2-entry queue lets input and output stall separately
`include "bgrx_to_yuv420_planar_assert.svh"
module bgrx_to_yuv420_planar #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [bgrx_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_red,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_plane,
  output logic [bgrx_pkg::OFF_W-1:0]     out_buffer_offset,
  output logic [bgrx_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                           out_last_of_pixel,
  output logic                           out_frame_done
);
  import bgrx_pkg::*;

  pixel_desc_t q_in, q_head;
  logic        q_push, q_full, q_pop, q_head_valid;

  bgrx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  bgrx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  bgrx_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_data         (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_plane         (out_plane),
    .out_buffer_offset (out_buffer_offset),
    .out_sample        (out_sample),
    .out_last_of_pixel (out_last_of_pixel),
    .out_frame_done    (out_frame_done)
  );

  // end of frame only ever closes a pixel
  `BGRX_ASSERT_SAME(a_done_is_last, out_valid && out_frame_done, out_last_of_pixel)
  // a v sample is always the last result of its pixel
  `BGRX_ASSERT_SAME(a_v_is_last, out_valid && (out_plane == PLANE_V), out_last_of_pixel)
  // a size write blocks input while the bases are rebuilt
  `BGRX_ASSERT_NEXT(a_cfg_blocks_input, cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT), !in_ready)

endmodule

// ===== tb/bgrx_to_yuv420_planar_tb.sv =====
// testbench for bgrx_to_yuv420_planar: random and directed pixel streams at several frame sizes
// predicts luma/chroma samples and planar offsets in-line, checks every result in order
// depends on bgrx_pkg and the bgrx_to_yuv420_planar rtl
module bgrx_to_yuv420_planar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgrx_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  // indexes the block does not decode
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    bit         drain;
  } pixel_t;

  typedef struct {
    plane_t             plane;
    logic [OFF_W-1:0]   offset;
    logic [7:0]         value;
    logic               last;
    logic               done;
  } sample_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = 2'd0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_blue = 8'd0;
  logic [7:0]          in_green = 8'd0;
  logic [7:0]          in_red = 8'd0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_plane;
  logic [OFF_W-1:0]    out_buffer_offset;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_last_of_pixel;
  logic                out_frame_done;

  // stimulus and expected samples
  pixel_t  pixel_queue[$];
  sample_t sample_queue[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_fire = 1'b0;
  int  stall_cycles = 0;
  int  mismatches = 0;

  // predicted block state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               col_cnt;
  int               line_cnt;
  logic [OFF_W-1:0] y_off;
  logic [OFF_W-1:0] u_off;
  logic [OFF_W-1:0] v_off;

  bgrx_to_yuv420_planar DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_plane         (out_plane),
    .out_buffer_offset (out_buffer_offset),
    .out_sample        (out_sample),
    .out_last_of_pixel (out_last_of_pixel),
    .out_frame_done    (out_frame_done)
  );

  always #5 clk = ~clk;

  // clamp to 2..max, then round down to even
  function automatic int clamp_size(input logic [CFG_W-1:0] v);
    int s;
    s = v;
    if (s < 2) s = 2;
    if (s > MAX_DIM) s = MAX_DIM;
    s = s & ~1;
    return s;
  endfunction

  // counters to zero, plane bases from the current sizes
  task automatic restart_frame_bases();
    int area;
    area = clamp_size(width_reg) * clamp_size(height_reg);
    col_cnt = 0;
    line_cnt = 0;
    y_off = '0;
    u_off = OFF_W'(area);
    v_off = OFF_W'(area + area / 4);
  endtask

  // predictor and result checker, all on the rising edge
  always @(posedge clk) begin : track
    int      bv, gv, rv, w, h, luma, cb, cr;
    bit      chroma, frame_end;
    sample_t want;
    in_fire <= in_valid && in_ready;
    if (!rst_n) begin
      width_reg = 13'd640;
      height_reg = 13'd480;
      restart_frame_bases();
      stall_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;

      // register writes restart the frame, unknown indexes do nothing
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_wdata;
          restart_frame_bases();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_wdata;
          restart_frame_bases();
        end
      end

      // compare an accepted result with the oldest expected sample
      if (out_valid && out_ready) begin
        if (sample_queue.size() == 0) begin
          $error("result with no pixel pending: plane %0d offset %0d sample %0d",
                 out_plane, out_buffer_offset, out_sample);
          mismatches++;
        end else begin
          want = sample_queue.pop_front();
          if (out_plane !== want.plane) begin
            $error("plane: expected %0d, actual %0d", want.plane, out_plane);
            mismatches++;
          end
          if (out_buffer_offset !== want.offset) begin
            $error("buffer_offset: expected %0d, actual %0d", want.offset,
                   out_buffer_offset);
            mismatches++;
          end
          if (out_sample !== want.value) begin
            $error("sample: expected %0d, actual %0d", want.value, out_sample);
            mismatches++;
          end
          if (out_last_of_pixel !== want.last) begin
            $error("last_of_pixel: expected %0d, actual %0d", want.last,
                   out_last_of_pixel);
            mismatches++;
          end
          if (out_frame_done !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, out_frame_done);
            mismatches++;
          end
        end
      end

      // accepted pixel: luma always, chroma on even line and even column
      if (in_valid && in_ready) begin
        bv = in_blue;
        gv = in_green;
        rv = in_red;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        chroma = (line_cnt % 2 == 0) && (col_cnt % 2 == 0);
        frame_end = (col_cnt + 1 >= w) && (line_cnt + 1 >= h);
        luma = ((66 * rv + 129 * gv + 25 * bv) >> 8) + 16;
        // bias of 128 << 8 keeps the shift a floor on a positive sum
        cb = (-38 * rv - 74 * gv + 112 * bv + 32768) >> 8;
        cr = (112 * rv - 94 * gv - 18 * bv + 32768) >> 8;
        sample_queue.push_back('{PLANE_Y, y_off, luma[7:0], !chroma,
                                 !chroma && frame_end});
        if (chroma) begin
          sample_queue.push_back('{PLANE_U, u_off, cb[7:0], 1'b0, 1'b0});
          sample_queue.push_back('{PLANE_V, v_off, cr[7:0], 1'b1, frame_end});
          u_off = u_off + 1'b1;
          v_off = v_off + 1'b1;
        end
        if (frame_end) begin
          restart_frame_bases();
        end else begin
          y_off = y_off + 1'b1;
          col_cnt++;
          if (col_cnt >= w) begin
            col_cnt = 0;
            line_cnt++;
          end
        end
      end
    end
  end

  // pixel driver and result back-pressure, on the falling edge
  always @(negedge clk) begin : drive
    pixel_t nxt;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst_n || !in_valid || in_fire) begin
      if (rst_n && pixel_queue.size() != 0 &&
          !(pixel_queue[0].drain && sample_queue.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_queue.pop_front();
        in_blue <= nxt.blue;
        in_green <= nxt.green;
        in_red <= nxt.red;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // channel value biased toward the extremes
  function automatic logic [7:0] rand_chan();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit drain);
    pixel_queue.push_back('{b, g, r, drain});
  endtask

  // random pixels, one of them held back until all samples are out
  task automatic queue_random(input int count);
    for (int k = 0; k < count; k++)
      push_pixel(rand_chan(), rand_chan(), rand_chan(), k == count / 2);
  endtask

  // nothing queued, nothing in flight
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_valid || sample_queue.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int w, input int h, input int count);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    queue_random(count);
  endtask

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset sizes, channel extremes and primaries
    send_idle_pct = 8;
    recv_idle_pct = 63;
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);

    // smallest frame, two full frames to see the wrap
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

    // odd sizes round down to even
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    for (int k = 0; k < 4; k++) push_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);

    // random, sender mostly busy and receiver mostly stalled
    run_phase(2, 2, 40);
    run_phase(4, 6, 60);
    run_phase(0, 8191, 30);

    // random, sender mostly idle and receiver mostly ready
    wait_idle();
    send_idle_pct = 63;
    recv_idle_pct = 8;
    run_phase(8191, 1, 40);
    run_phase(4096, 4096, 30);
    run_phase(7, 5, 80);
    // unknown indexes mid-frame must not restart it
    wait_idle();
    write_reg(REG_SPARE_A, CFG_W'($urandom_range(8191)));
    write_reg(REG_SPARE_B, CFG_W'($urandom_range(8191)));
    queue_random(50);

    // random, full rate both ways
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FRAME_HEIGHT, 2);
    queue_random(50);
    run_phase(16, 6, 70);
    run_phase(2, 4096, 30);

    // let any stray results show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && sample_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
